// ===== sv/plop_pkg.sv =====
// shared types, constants and codes for the packet layer offset parser
package plop_pkg;

    // default upper bound of the saturating byte position
    localparam int FRAME_LEN_MAX_DEF = 16383;

    // result offsets are reported modulo this width
    localparam int OFF_W = 14;

    // ethertype codes
    localparam logic [15:0] ETYPE_VLAN_C  = 16'h8100;
    localparam logic [15:0] ETYPE_VLAN_S  = 16'h88A8;
    localparam logic [15:0] ETYPE_VLAN_Q  = 16'h9100;
    localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6    = 16'h86DD;

    // ip protocol numbers
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // header geometry in bytes
    localparam int ETH_TYPE_HI_POS = 12;
    localparam int ETH_TYPE_LO_POS = 13;
    localparam int ETH_HDR_LEN     = 14;
    localparam int VLAN_TYPE_HI    = 2;
    localparam int VLAN_TYPE_LO    = 3;
    localparam int VLAN_TAG_LEN    = 4;
    localparam int IPV4_PROTO_POS  = 9;
    localparam int IPV4_MIN_LEN    = 20;
    localparam int IPV6_NXT_POS    = 6;
    localparam int IPV6_HDR_LEN    = 40;
    localparam int TCP_DOFF_POS    = 12;
    localparam int TCP_MIN_LEN     = 20;
    localparam int TCP_MIN_WORDS   = 5;
    localparam int UDP_HDR_LEN     = 8;

    // parse phase of the frame being received
    typedef enum logic [2:0] {
        PH_ETH,
        PH_VLAN,
        PH_IPV4,
        PH_IPV6,
        PH_OTHER
    } t_phase;

    typedef logic [OFF_W-1:0] t_off;

    // input word: one frame byte with its end mark
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       last_byte;
    } t_in_word;

    // output word: offsets and transport flags of one frame
    typedef struct packed {
        t_off network_offset;
        t_off transport_offset;
        t_off payload_offset;
        logic is_tcp;
        logic is_udp;
    } t_out_word;

endpackage

// ===== sv/plop_stream_if.sv =====
// valid/ready stream interface carrying one word per handshake
interface plop_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/plop_tracker.sv =====
// header tracking state and end-of-frame offset decision
module plop_tracker
    import plop_pkg::*;
#(
    parameter int FRAME_LEN_MAX = FRAME_LEN_MAX_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_word  i_word,
    output t_out_word o_result
);

    localparam int PW = $clog2(FRAME_LEN_MAX + 1);
    localparam int OW = PW + 2;
    localparam logic [PW-1:0] POS_MAX = PW'(FRAME_LEN_MAX);

    logic [PW-1:0] r_pos,   n_pos;
    t_phase        r_phase, n_phase;
    logic [15:0]   r_type,  n_type;
    logic [PW-1:0] r_net,   n_net;
    logic [OW-1:0] r_trans, n_trans;
    logic [7:0]    r_proto, n_proto;
    logic [3:0]    r_hw,    n_hw;

    // byte update of the header state
    always_comb begin
        logic [OW-1:0] pos_e;
        logic [OW-1:0] net_e;
        logic [15:0]   t_new;
        logic [PW-1:0] off;
        logic          do_enter;
        n_pos    = r_pos;
        n_phase  = r_phase;
        n_type   = r_type;
        n_net    = r_net;
        n_trans  = r_trans;
        n_proto  = r_proto;
        n_hw     = r_hw;
        pos_e    = OW'(r_pos);
        net_e    = OW'(r_net);
        t_new    = r_type;
        off      = r_net;
        do_enter = 1'b0;
        if (r_pos < POS_MAX) begin
            n_pos = r_pos + PW'(1);
            unique case (r_phase)
                PH_ETH: begin
                    if (pos_e == OW'(ETH_TYPE_HI_POS)) begin
                        n_type = {i_word.frame_byte, 8'h00};
                    end else if (pos_e == OW'(ETH_TYPE_LO_POS)) begin
                        t_new    = {r_type[15:8], i_word.frame_byte};
                        off      = PW'(ETH_HDR_LEN);
                        do_enter = 1'b1;
                    end
                end
                PH_VLAN: begin
                    if (pos_e == net_e + OW'(VLAN_TYPE_HI)) begin
                        n_type = {i_word.frame_byte, 8'h00};
                    end else if (pos_e == net_e + OW'(VLAN_TYPE_LO)) begin
                        t_new    = {r_type[15:8], i_word.frame_byte};
                        off      = PW'(net_e + OW'(VLAN_TAG_LEN));
                        do_enter = 1'b1;
                    end
                end
                PH_IPV4: begin
                    if (pos_e == net_e) begin
                        n_hw    = i_word.frame_byte[3:0];
                        n_trans = net_e + OW'({i_word.frame_byte[3:0], 2'b00});
                    end else if (pos_e == net_e + OW'(IPV4_PROTO_POS)) begin
                        n_proto = i_word.frame_byte;
                    end else if (pos_e == r_trans + OW'(TCP_DOFF_POS)) begin
                        n_hw = i_word.frame_byte[7:4];
                    end
                end
                PH_IPV6: begin
                    if (pos_e == net_e + OW'(IPV6_NXT_POS)) begin
                        n_proto = i_word.frame_byte;
                    end else if (pos_e == r_trans + OW'(TCP_DOFF_POS)) begin
                        n_hw = i_word.frame_byte[7:4];
                    end
                end
                default: begin
                end
            endcase
        end
        // next header type once the ethertype is complete
        if (do_enter) begin
            n_type = t_new;
            n_net  = off;
            if (t_new == ETYPE_VLAN_C || t_new == ETYPE_VLAN_S || t_new == ETYPE_VLAN_Q) begin
                n_phase = PH_VLAN;
            end else if (t_new == ETYPE_IPV4) begin
                n_phase = PH_IPV4;
            end else if (t_new == ETYPE_IPV6) begin
                n_phase = PH_IPV6;
                n_trans = OW'(off) + OW'(IPV6_HDR_LEN);
            end else begin
                n_phase = PH_OTHER;
            end
        end
    end

    // offsets and flags from the state after this byte
    always_comb begin
        logic [OW-1:0] cap;
        logic [OW-1:0] net_e;
        logic [OW-1:0] l3;
        logic [OW-1:0] l4;
        logic [OW-1:0] l7;
        logic [OW-1:0] tcp_end;
        logic          ip_ok;
        logic          tcp;
        logic          udp;
        cap     = OW'(n_pos);
        net_e   = OW'(n_net);
        tcp_end = n_trans + OW'({n_hw, 2'b00});
        l3      = '0;
        l4      = '0;
        l7      = '0;
        ip_ok   = 1'b0;
        tcp     = 1'b0;
        udp     = 1'b0;
        unique case (n_phase)
            PH_OTHER: begin
                l3 = net_e;
                l4 = net_e;
                l7 = net_e;
            end
            PH_IPV4: begin
                l3 = net_e;
                l4 = net_e;
                l7 = net_e;
                ip_ok = (cap >= net_e + OW'(IPV4_MIN_LEN))
                     && (n_trans >= net_e + OW'(IPV4_MIN_LEN))
                     && (cap >= n_trans);
            end
            PH_IPV6: begin
                l3 = net_e;
                l4 = net_e;
                l7 = net_e;
                ip_ok = (cap >= net_e + OW'(IPV6_HDR_LEN));
            end
            default: begin
            end
        endcase
        // transport header once the ip header is accepted
        if (ip_ok) begin
            l4 = n_trans;
            l7 = n_trans;
            if (n_proto == PROTO_TCP) begin
                tcp = 1'b1;
                if ((cap >= n_trans + OW'(TCP_MIN_LEN)) && (n_hw >= 4'(TCP_MIN_WORDS))
                        && (cap >= tcp_end)) begin
                    l7 = tcp_end;
                end
            end else if (n_proto == PROTO_UDP) begin
                udp = 1'b1;
                if (cap >= n_trans + OW'(UDP_HDR_LEN)) begin
                    l7 = n_trans + OW'(UDP_HDR_LEN);
                end
            end
        end
        o_result.network_offset   = t_off'(l3);
        o_result.transport_offset = t_off'(l4);
        o_result.payload_offset   = t_off'(l7);
        o_result.is_tcp           = tcp;
        o_result.is_udp           = udp;
    end

    // state registers, cleared at reset and after each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_word.last_byte)) begin
            r_pos   <= '0;
            r_phase <= PH_ETH;
            r_type  <= '0;
            r_net   <= '0;
            r_trans <= '0;
            r_proto <= '0;
            r_hw    <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_type  <= n_type;
            r_net   <= n_net;
            r_trans <= n_trans;
            r_proto <= n_proto;
            r_hw    <= n_hw;
        end
    end

endmodule

// ===== sv/packet_layer_offset_parser_core.sv =====
// top level of the packet layer offset parser
//
// Input channel i_in carries one captured frame byte per word, in order, with
// last_byte set on the final byte of each frame. Output channel o_out carries
// one word per frame: network, transport and payload byte offsets and the
// TCP/UDP flags, all decided from the bytes seen up to the last one.
// Bytes past FRAME_LEN_MAX are counted as no further length and not parsed.
// Throughput is one byte per clock unless a frame end meets a full output
// register: an input register feeds the header tracker, whose update and
// offset decision are combinational into the output register. The result
// word is loaded into the output register when the last byte leaves the
// input register. Only words that end a frame need room at the output, so a
// stalled receiver holds back the input only once a frame end meets a full
// output register; bytes in mid-frame keep flowing. Reset (synchronous,
// active low) empties both registers and returns the tracker to the start
// of a frame.
module packet_layer_offset_parser_core
    import plop_pkg::*;
#(
    parameter int FRAME_LEN_MAX = FRAME_LEN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    plop_stream_if.sink   i_in,
    plop_stream_if.source o_out
);

    logic      r_in_valid;
    t_in_word  r_in;
    logic      r_out_valid;
    t_out_word r_out;
    logic      advance;
    t_out_word result;

    // a byte moves on unless it ends a frame and the output is still full
    assign advance = r_in_valid && (!r_in.last_byte || !r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in <= i_in.data;
        end
    end

    // header tracker
    plop_tracker #(
        .FRAME_LEN_MAX (FRAME_LEN_MAX)
    ) u_tracker (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (advance),
        .i_word   (r_in),
        .o_result (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in.last_byte) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in.last_byte) begin
            r_out <= result;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule

// ===== tb/sv/plop_offset_checker.sv =====
`timescale 1ns / 1ps
// checker for the offset parser: header tracking per input word and offset word comparison
module plop_offset_checker
    import plop_pkg::*;
#(
    parameter int FRAME_LEN_MAX = FRAME_LEN_MAX_DEF
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    plop_stream_if i_in,
    plop_stream_if i_out,
    output int     o_fail_count,
    output int     o_pending,
    output int     o_checked
);

    // positions kept wider than the offsets so header sums never wrap
    typedef logic [16:0] t_pos;

    // header tracker state
    t_pos        pos_cnt;
    t_phase      phase;
    logic [15:0] etype_acc;
    t_pos        net_at;
    t_pos        l4_at;
    t_pos        l7_at;
    logic [7:0]  ip_proto;
    logic [3:0]  hdr_words;

    // offset words still owed by the block, oldest first
    t_out_word offsets_due[$];

    int fails     = 0;
    int checked   = 0;
    int due_count = 0;

    assign o_fail_count = fails;
    assign o_pending    = due_count;
    assign o_checked    = checked;

    function automatic logic is_tag_type(input logic [15:0] t);
        return t == ETYPE_VLAN_C || t == ETYPE_VLAN_S || t == ETYPE_VLAN_Q;
    endfunction

    // back to the start of a frame
    task automatic clear_frame();
        pos_cnt   = '0;
        phase     = PH_ETH;
        etype_acc = '0;
        net_at    = '0;
        l4_at     = '0;
        l7_at     = '0;
        ip_proto  = '0;
        hdr_words = '0;
    endtask

    // a type field is complete: pick the header that starts at this position
    task automatic open_type(input t_pos at);
        net_at = at;
        if (is_tag_type(etype_acc)) begin
            phase = PH_VLAN;
        end else if (etype_acc == ETYPE_IPV4) begin
            phase = PH_IPV4;
        end else if (etype_acc == ETYPE_IPV6) begin
            phase = PH_IPV6;
            l4_at = t_pos'(at + IPV6_HDR_LEN);
        end else begin
            phase = PH_OTHER;
        end
    endtask

    // header fields picked out of one byte at position p
    task automatic parse_byte(input t_pos p, input logic [7:0] b);
        case (phase)
            PH_ETH: begin
                if (p == ETH_TYPE_HI_POS) begin
                    etype_acc = {b, 8'h00};
                end else if (p == ETH_TYPE_LO_POS) begin
                    etype_acc = etype_acc | {8'h00, b};
                    open_type(t_pos'(ETH_HDR_LEN));
                end
            end
            PH_VLAN: begin
                if (p == net_at + VLAN_TYPE_HI) begin
                    etype_acc = {b, 8'h00};
                end else if (p == net_at + VLAN_TYPE_LO) begin
                    etype_acc = etype_acc | {8'h00, b};
                    open_type(t_pos'(net_at + VLAN_TAG_LEN));
                end
            end
            PH_IPV4: begin
                if (p == net_at) begin
                    hdr_words = b[3:0];
                    l4_at     = net_at + {hdr_words, 2'b00};
                end else if (p == net_at + IPV4_PROTO_POS) begin
                    ip_proto = b;
                end else if (p == l4_at + TCP_DOFF_POS) begin
                    hdr_words = b[7:4];
                end
            end
            PH_IPV6: begin
                if (p == net_at + IPV6_NXT_POS) begin
                    ip_proto = b;
                end else if (p == l4_at + TCP_DOFF_POS) begin
                    hdr_words = b[7:4];
                end
            end
            default: ;
        endcase
    endtask

    // transport flags and payload start once the ip header is accepted
    task automatic settle_l4(input t_pos caplen, output logic tcp, output logic udp);
        tcp   = 1'b0;
        udp   = 1'b0;
        l7_at = l4_at;
        if (ip_proto == PROTO_TCP) begin
            tcp = 1'b1;
            if (caplen >= l4_at + TCP_MIN_LEN && hdr_words >= TCP_MIN_WORDS &&
                caplen >= l4_at + {hdr_words, 2'b00})
                l7_at = l4_at + {hdr_words, 2'b00};
        end else if (ip_proto == PROTO_UDP) begin
            udp = 1'b1;
            if (caplen >= l4_at + UDP_HDR_LEN)
                l7_at = t_pos'(l4_at + UDP_HDR_LEN);
        end
    endtask

    // one accepted input word; a frame end queues the offsets it should give
    task automatic track_byte(input logic [7:0] b, input logic last);
        t_pos      caplen;
        t_pos      l3;
        t_pos      l4;
        t_pos      l7;
        logic      tcp;
        logic      udp;
        logic      hdr_ok;
        t_out_word due;
        if (pos_cnt < FRAME_LEN_MAX) begin
            parse_byte(pos_cnt, b);
            pos_cnt = pos_cnt + 1'b1;
        end
        if (last) begin
            caplen = pos_cnt;
            l3     = '0;
            l4     = '0;
            l7     = '0;
            tcp    = 1'b0;
            udp    = 1'b0;
            case (phase)
                PH_OTHER: begin
                    l3 = net_at;
                    l4 = net_at;
                    l7 = net_at;
                end
                PH_IPV4, PH_IPV6: begin
                    l3 = net_at;
                    l4 = net_at;
                    l7 = net_at;
                    if (phase == PH_IPV4)
                        hdr_ok = caplen >= net_at + IPV4_MIN_LEN &&
                                 l4_at >= net_at + IPV4_MIN_LEN && caplen >= l4_at;
                    else
                        hdr_ok = caplen >= net_at + IPV6_HDR_LEN;
                    if (hdr_ok) begin
                        settle_l4(caplen, tcp, udp);
                        l4 = l4_at;
                        l7 = l7_at;
                    end
                end
                // short frame or end inside a tag: all zero
                default: ;
            endcase
            due.network_offset   = l3[OFF_W-1:0];
            due.transport_offset = l4[OFF_W-1:0];
            due.payload_offset   = l7[OFF_W-1:0];
            due.is_tcp           = tcp;
            due.is_udp           = udp;
            offsets_due.push_back(due);
            clear_frame();
        end
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            fails++;
        end
    endtask

    // compare the outgoing word first, then take the incoming one
    always @(posedge i_clk) begin : watch
        t_out_word want;
        if (!i_rst_n) begin
            clear_frame();
            offsets_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                if (offsets_due.size() == 0) begin
                    $display("%0t: offset word with none expected: net %0d trans %0d pay %0d tcp %0b udp %0b",
                             $time, i_out.data.network_offset, i_out.data.transport_offset,
                             i_out.data.payload_offset, i_out.data.is_tcp, i_out.data.is_udp);
                    fails++;
                end else begin
                    want = offsets_due.pop_front();
                    check_field("network_offset", want.network_offset,
                                i_out.data.network_offset);
                    check_field("transport_offset", want.transport_offset,
                                i_out.data.transport_offset);
                    check_field("payload_offset", want.payload_offset,
                                i_out.data.payload_offset);
                    check_field("is_tcp", want.is_tcp, i_out.data.is_tcp);
                    check_field("is_udp", want.is_udp, i_out.data.is_udp);
                    checked++;
                end
            end
            if (i_in.valid && i_in.ready)
                track_byte(i_in.data.frame_byte, i_in.data.last_byte);
        end
        due_count = offsets_due.size();
    end

endmodule

// ===== tb/sv/tb_packet_layer_offset_parser_core.sv =====
`timescale 1ns / 1ps
// testbench top for the offset parser: frame stimulus, handshake pacing and verdict
module tb_packet_layer_offset_parser_core;
    import plop_pkg::*;

    // ethertype and protocol codes used only for stimulus
    localparam logic [15:0] ETYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP = 8'd1;

    // handshake pacing mixes
    typedef enum int {
        PACE_NONE,
        PACE_SEND,
        PACE_RECV,
        PACE_BOTH
    } t_pace;

    // shape of one generated frame
    typedef struct {
        int          n_tags;
        logic [15:0] etype;
        int          ihl;
        logic [7:0]  proto;
        int          doff;
        int          pay_len;
        int          cut;      // 0 keeps the whole frame, -1 cuts at a random length
    } t_frame_spec;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int         fail_count;
    int         pending;
    int         checked;
    t_pace      pace;
    int         bytes_sent;
    int         frames_sent;
    logic [7:0] frame_bytes[$];

    plop_stream_if #(.T(t_in_word))  in_ch ();
    plop_stream_if #(.T(t_out_word)) out_ch ();

    packet_layer_offset_parser_core DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    plop_offset_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    initial begin
        #5000000;
        $display("run timed out");
        $display("Mismatches found");
        $finish;
    end

    // idle decision for one side in the current pacing mix
    function automatic logic idle_roll(input logic recv_side);
        int pct;
        case (pace)
            PACE_SEND: pct = recv_side ? 0 : 68;
            PACE_RECV: pct = recv_side ? 68 : 0;
            PACE_BOTH: pct = 30;
            default:   pct = 0;
        endcase
        return $urandom_range(0, 99) < pct;
    endfunction

    // receiver stalls, changed at the falling edge
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_ch.ready <= !idle_roll(1'b1);
        end
    end

    // one input word; entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic last);
        while (idle_roll(1'b0)) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= '{frame_byte: b, last_byte: last};
        @(posedge i_clk);
        while (!(in_ch.valid && in_ch.ready))
            @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        frames_sent++;
    endtask

    // ethernet, tags, ip and transport headers with random content, then payload
    task automatic build_frame(input t_frame_spec s);
        int          hdr_len;
        int          len;
        logic [15:0] tpid;
        frame_bytes.delete();
        repeat (12) frame_bytes.push_back(8'($urandom));
        for (int t = 0; t < s.n_tags; t++) begin
            case ($urandom_range(0, 2))
                0:       tpid = ETYPE_VLAN_C;
                1:       tpid = ETYPE_VLAN_S;
                default: tpid = ETYPE_VLAN_Q;
            endcase
            frame_bytes.push_back(tpid[15:8]);
            frame_bytes.push_back(tpid[7:0]);
            repeat (2) frame_bytes.push_back(8'($urandom));
        end
        frame_bytes.push_back(s.etype[15:8]);
        frame_bytes.push_back(s.etype[7:0]);
        if (s.etype == ETYPE_IPV4 || s.etype == ETYPE_IPV6) begin
            // ip header
            if (s.etype == ETYPE_IPV4) begin
                hdr_len = (s.ihl < TCP_MIN_WORDS) ? IPV4_MIN_LEN : s.ihl * 4;
                frame_bytes.push_back({4'h4, 4'(s.ihl)});
                for (int i = 1; i < hdr_len; i++)
                    frame_bytes.push_back((i == IPV4_PROTO_POS) ? s.proto : 8'($urandom));
            end else begin
                frame_bytes.push_back({4'h6, 4'($urandom)});
                for (int i = 1; i < IPV6_HDR_LEN; i++)
                    frame_bytes.push_back((i == IPV6_NXT_POS) ? s.proto : 8'($urandom));
            end
            // transport header
            if (s.proto == PROTO_TCP) begin
                hdr_len = (s.doff < TCP_MIN_WORDS) ? TCP_MIN_LEN : s.doff * 4;
                for (int i = 0; i < hdr_len; i++)
                    frame_bytes.push_back((i == TCP_DOFF_POS) ?
                                          {4'(s.doff), 4'($urandom)} : 8'($urandom));
            end else if (s.proto == PROTO_UDP) begin
                repeat (UDP_HDR_LEN) frame_bytes.push_back(8'($urandom));
            end
        end
        repeat (s.pay_len) frame_bytes.push_back(8'($urandom));
        len = frame_bytes.size();
        if (s.cut < 0)
            len = $urandom_range(1, len);
        else if (s.cut > 0 && s.cut < len)
            len = s.cut;
        while (frame_bytes.size() > len)
            void'(frame_bytes.pop_back());
    endtask

    task automatic run_spec(input t_frame_spec s);
        build_frame(s);
        send_frame();
    endtask

    // mostly well-formed frames with random content, some noise
    task automatic random_frame();
        t_frame_spec s;
        int          roll;
        if ($urandom_range(0, 99) < 12) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 80)) frame_bytes.push_back(8'($urandom));
            send_frame();
        end else begin
            roll     = $urandom_range(0, 99);
            s.n_tags = (roll < 50) ? 0 : (roll < 75) ? 1 : (roll < 90) ? 2 : 3;
            roll     = $urandom_range(0, 99);
            s.etype  = (roll < 45) ? ETYPE_IPV4 : (roll < 80) ? ETYPE_IPV6 : 16'($urandom);
            roll     = $urandom_range(0, 99);
            s.ihl    = (roll < 50) ? 5 : (roll < 85) ? $urandom_range(6, 15) :
                                                      $urandom_range(0, 4);
            roll     = $urandom_range(0, 99);
            s.proto  = (roll < 45) ? PROTO_TCP : (roll < 85) ? PROTO_UDP : 8'($urandom);
            roll     = $urandom_range(0, 99);
            s.doff   = (roll < 50) ? 5 : (roll < 85) ? $urandom_range(6, 15) :
                                                      $urandom_range(0, 4);
            s.pay_len = $urandom_range(0, 40);
            s.cut     = ($urandom_range(0, 99) < 30) ? -1 : 0;
            run_spec(s);
        end
    endtask

    // stimulus and verdict
    initial begin
        int start_bytes;
        int start_frames;
        i_rst_n     = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        pace        = PACE_NONE;
        bytes_sent  = 0;
        frames_sent = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // short frames and a frame ending inside a tag
        run_spec('{0, ETYPE_IPV4, 5, PROTO_TCP, 5, 10, 1});
        run_spec('{0, ETYPE_IPV4, 5, PROTO_TCP, 5, 10, 13});
        run_spec('{0, ETYPE_IPV4, 5, PROTO_TCP, 5, 10, 14});
        run_spec('{1, ETYPE_IPV4, 5, PROTO_TCP, 5, 10, 16});
        // non-ip type
        run_spec('{0, ETYPE_ARP, 5, PROTO_TCP, 5, 46, 0});
        // ipv4: minimum and maximum header lengths, bad and truncated headers
        run_spec('{0, ETYPE_IPV4, 5, PROTO_TCP, 5, 16, 0});
        run_spec('{0, ETYPE_IPV4, 15, PROTO_TCP, 15, 8, 0});
        run_spec('{0, ETYPE_IPV4, 4, PROTO_TCP, 5, 20, 0});
        run_spec('{0, ETYPE_IPV4, 15, PROTO_TCP, 5, 20, 54});
        run_spec('{0, ETYPE_IPV4, 5, PROTO_UDP, 5, 20, 33});
        // udp whole and truncated
        run_spec('{0, ETYPE_IPV4, 5, PROTO_UDP, 5, 12, 0});
        run_spec('{0, ETYPE_IPV4, 5, PROTO_UDP, 5, 12, 39});
        // tcp truncated, data offset too small, header longer than the capture
        run_spec('{0, ETYPE_IPV4, 5, PROTO_TCP, 5, 12, 44});
        run_spec('{0, ETYPE_IPV4, 5, PROTO_TCP, 4, 20, 0});
        run_spec('{0, ETYPE_IPV4, 5, PROTO_TCP, 15, 0, 74});
        // unknown transport protocol
        run_spec('{0, ETYPE_IPV4, 5, PROTO_ICMP, 5, 8, 0});
        // ipv6 variants
        run_spec('{0, ETYPE_IPV6, 5, PROTO_TCP, 8, 4, 0});
        run_spec('{0, ETYPE_IPV6, 5, PROTO_UDP, 5, 0, 0});
        run_spec('{0, ETYPE_IPV6, 5, PROTO_UDP, 5, 0, 53});
        run_spec('{0, ETYPE_IPV6, 5, PROTO_ICMP, 5, 10, 0});
        // stacked tags
        run_spec('{2, ETYPE_IPV4, 5, PROTO_UDP, 5, 6, 0});
        run_spec('{3, ETYPE_IPV6, 5, PROTO_TCP, 5, 0, 0});
        // byte extremes: all zero and all ones
        frame_bytes.delete();
        repeat (64) frame_bytes.push_back(8'h00);
        send_frame();
        frame_bytes.delete();
        repeat (64) frame_bytes.push_back(8'hFF);
        send_frame();

        // random frames under each pacing mix
        for (int ph = 0; ph < 4; ph++) begin
            pace         = t_pace'(ph);
            start_bytes  = bytes_sent;
            start_frames = frames_sent;
            while (bytes_sent - start_bytes < 160 || frames_sent - start_frames < 3)
                random_frame();
        end
        in_ch.valid <= 1'b0;

        wait (pending == 0);
        repeat (8) @(posedge i_clk);
        $display("covered %0d frames, %0d bytes: short, tagged, non-ip, ipv4/ipv6 tcp/udp, truncated",
                 frames_sent, bytes_sent);
        $display("%0d offset words compared under four handshake pacing mixes", checked);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/plop_pkg.sv
sv/plop_stream_if.sv
sv/plop_tracker.sv
sv/packet_layer_offset_parser_core.sv
tb/sv/plop_offset_checker.sv
tb/sv/tb_packet_layer_offset_parser_core.sv
